// ----- design/msd_pkg.sv -----
`default_nettype none

package msd_pkg;

    // Character codes that carry Morse symbols.
    localparam logic [7:0] SYM_DOT  = 8'h2E;
    localparam logic [7:0] SYM_DASH = 8'h2D;

    // Group length limits; the counter saturates at TOO_LONG.
    localparam logic [2:0] MAX_SYMBOLS = 3'd4;
    localparam logic [2:0] TOO_LONG    = 3'd5;

    // Classified character as it travels from the front to the back part.
    typedef struct packed {
        logic is_sym;
        logic is_dash;
        logic last;
    } t_token;

    // Letter at a node of the Morse binary tree: root 1, a dot goes to 2n,
    // a dash to 2n + 1. Nodes without a letter give 0.
    function automatic logic [7:0] node_letter(input logic [4:0] node);
        logic [7:0] letter_code;
        unique case (node)
            5'd2:    letter_code = "E";
            5'd3:    letter_code = "T";
            5'd4:    letter_code = "I";
            5'd5:    letter_code = "A";
            5'd6:    letter_code = "N";
            5'd7:    letter_code = "M";
            5'd8:    letter_code = "S";
            5'd9:    letter_code = "U";
            5'd10:   letter_code = "R";
            5'd11:   letter_code = "W";
            5'd12:   letter_code = "D";
            5'd13:   letter_code = "K";
            5'd14:   letter_code = "G";
            5'd15:   letter_code = "O";
            5'd16:   letter_code = "H";
            5'd17:   letter_code = "V";
            5'd18:   letter_code = "F";
            5'd20:   letter_code = "L";
            5'd22:   letter_code = "P";
            5'd23:   letter_code = "J";
            5'd24:   letter_code = "B";
            5'd25:   letter_code = "X";
            5'd26:   letter_code = "C";
            5'd27:   letter_code = "Y";
            5'd28:   letter_code = "Z";
            5'd29:   letter_code = "Q";
            default: letter_code = 8'd0;
        endcase
        return letter_code;
    endfunction

endpackage

`default_nettype wire

// ----- design/msd_front.sv -----
`default_nettype none

module msd_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    // Input character stream.
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    input  wire logic [7:0]      i_s_tdata,
    input  wire logic            i_s_tlast,
    // Classified token toward the queue.
    output logic                 o_tok_valid,
    input  wire logic            i_tok_ready,
    output msd_pkg::t_token      o_tok
);

    logic            r_valid;
    msd_pkg::t_token r_tok;
    msd_pkg::t_token n_tok;

    // The stage takes a new request whenever it is empty or is being drained.
    assign o_s_tready  = !r_valid || i_tok_ready;
    assign o_tok_valid = r_valid;
    assign o_tok       = r_tok;

    // Classify the character as dot, dash or separator.
    always_comb begin
        n_tok.is_dash = (i_s_tdata == msd_pkg::SYM_DASH);
        n_tok.is_sym  = (i_s_tdata == msd_pkg::SYM_DOT) || n_tok.is_dash;
        n_tok.last    = i_s_tlast;
    end

    // Stage valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_tok <= n_tok;
        end
    end

endmodule

`default_nettype wire

// ----- design/msd_queue.sv -----
`default_nettype none

module msd_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push_valid,
    output logic                 o_push_ready,
    input  wire msd_pkg::t_token i_push_tok,
    output logic                 o_pop_valid,
    input  wire logic            i_pop_ready,
    output msd_pkg::t_token      o_pop_tok
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    msd_pkg::t_token r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_cnt;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_cnt != FULL_CNT);
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_tok    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // Token storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_tok;
        end
    end

endmodule

`default_nettype wire

// ----- design/msd_back.sv -----
`default_nettype none

module msd_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    // Tokens from the queue.
    input  wire logic            i_tok_valid,
    output logic                 o_tok_ready,
    input  wire msd_pkg::t_token i_tok,
    // Result stream.
    output logic                 o_m_tvalid,
    input  wire logic            i_m_tready,
    output logic [7:0]           o_m_tdata,  // [7:0] letter
    output logic                 o_m_tlast,  // line_end
    output logic [1:0]           o_m_tuser   // [0] has_letter, [1] unknown_code
);

    logic [2:0] r_cnt;
    logic [3:0] r_pat;
    logic       r_valid;
    logic [7:0] r_letter;
    logic       r_has;
    logic       r_unk;
    logic       r_lend;

    logic [2:0] sym_cnt;
    logic [3:0] sym_pat;
    logic [2:0] n_cnt;
    logic [3:0] n_pat;
    logic [4:0] node;
    logic [7:0] dec_letter;
    logic       emit;
    logic       n_has;
    logic       take;

    // A token is taken when the output register is free or being drained.
    assign o_tok_ready = !r_valid || i_m_tready;
    assign take        = i_tok_valid && o_tok_ready;

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_letter;
    assign o_m_tlast  = r_lend;
    assign o_m_tuser  = {r_unk, r_has};

    // Symbols extend the group; past four symbols the counter saturates.
    always_comb begin
        sym_cnt = r_cnt;
        sym_pat = r_pat;
        if (i_tok.is_sym) begin
            if (r_cnt < msd_pkg::MAX_SYMBOLS) begin
                sym_pat = {r_pat[2:0], i_tok.is_dash};
                sym_cnt = r_cnt + 3'd1;
            end else begin
                sym_cnt = msd_pkg::TOO_LONG;
            end
        end
    end

    // Tree node of the pending group: a leading one above the used symbols.
    always_comb begin
        unique case (sym_cnt)
            3'd1:    node = {4'b0001, sym_pat[0]};
            3'd2:    node = {3'b001, sym_pat[1:0]};
            3'd3:    node = {2'b01, sym_pat[2:0]};
            3'd4:    node = {1'b1, sym_pat[3:0]};
            default: node = 5'd0;
        endcase
        dec_letter = msd_pkg::node_letter(node);
    end

    // A separator or the end of a line closes the group.
    always_comb begin
        emit  = 1'b0;
        n_has = 1'b0;
        n_cnt = sym_cnt;
        n_pat = sym_pat;
        if (!i_tok.is_sym || i_tok.last) begin
            if (sym_cnt != 3'd0) begin
                emit  = 1'b1;
                n_has = 1'b1;
                n_cnt = 3'd0;
                n_pat = 4'd0;
            end else begin
                emit = i_tok.last;
            end
        end
    end

    // Group state and output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= 3'd0;
            r_pat   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_cnt <= n_cnt;
                r_pat <= n_pat;
            end
            if (o_tok_ready) begin
                r_valid <= take && emit;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_letter <= n_has ? dec_letter : 8'd0;
            r_has    <= n_has;
            r_unk    <= n_has && (dec_letter == 8'd0);
            r_lend   <= i_tok.last;
        end
    end

endmodule

`default_nettype wire

// ----- design/morse_stream_decoder.sv -----
`default_nettype none

// Morse stream decoder for the letters A to Z. One ASCII character is taken
// per clock cycle while the token queue has room, with tlast marking the
// last character of a line; dots and dashes build a group of up to four
// symbols, and any other character, or the end of a line, closes it and
// sends one result: the letter with has_letter set, letter 0 with
// unknown_code set for an unknown or too long group, or an empty result
// with tlast set for a line that ends with nothing pending. A new character
// is accepted every cycle while the queue has room; a result passes the
// classify register, token queue and output register, and the QUEUE_DEPTH
// entry queue lets the input side keep going while the result side stalls.
module morse_stream_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,  // [7:0] char_in
    input  wire logic        i_s_tlast,  // line_last
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,  // [7:0] letter
    output logic             o_m_tlast,  // line_end
    output logic [1:0]       o_m_tuser   // [0] has_letter, [1] unknown_code
);

    logic            fr_valid;
    logic            fr_ready;
    msd_pkg::t_token fr_tok;
    logic            bk_valid;
    logic            bk_ready;
    msd_pkg::t_token bk_tok;

    // Front part: accept and classify characters.
    msd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_tok_valid (fr_valid),
        .i_tok_ready (fr_ready),
        .o_tok       (fr_tok)
    );

    // Token queue between the two parts.
    msd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fr_valid),
        .o_push_ready (fr_ready),
        .i_push_tok   (fr_tok),
        .o_pop_valid  (bk_valid),
        .i_pop_ready  (bk_ready),
        .o_pop_tok    (bk_tok)
    );

    // Back part: group state, decoding and result register.
    msd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (bk_valid),
        .o_tok_ready (bk_ready),
        .i_tok       (bk_tok),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

`default_nettype wire

// ----- sim/morse_stream_decoder_test.sv -----
`timescale 1ns / 100ps

module morse_stream_decoder_test;

    // One decoded result as it leaves the block.
    typedef struct packed {
        logic [7:0] letter;
        logic       has_letter;
        logic       unknown_code;
        logic       line_end;
    } t_decoded;

    // Letters of the Morse tree by node index, node 0 first; '*' marks no letter.
    localparam logic [8*32-1:0] TREE_LETTERS = "**ETIANMSURWDKGOHVF*L*PJBXCYZQ**";
    localparam logic [7:0]      CHAR_SPACE     = 8'h20;
    localparam int              IDLE_MAX       = 10;
    localparam int              TAIL_CYCLES    = 8;
    localparam int              WATCHDOG_LIMIT = 1000;
    localparam int              RANDOM_ITEMS   = 1530;
    localparam int              MODE_STRETCH   = 150;

    logic       i_clk      = 1'b0;
    logic       rst_n      = 1'b0;
    logic       s_tvalid   = 1'b0;
    logic [7:0] s_tdata    = 8'd0;
    logic       s_tlast    = 1'b0;
    logic       m_tready   = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;    // [7:0] letter
    logic       m_tlast;    // line_end
    logic [1:0] m_tuser;    // [0] has_letter, [1] unknown_code

    // Decoder state as the checker sees it.
    logic [2:0] group_len     = 3'd0;
    logic [3:0] group_symbols = 4'd0;

    t_decoded   expected_letters[$];
    int         error_count = 0;
    int         items_sent  = 0;
    int         quiet_cycles = 0;
    bit         send_idle = 1'b1;
    bit         recv_idle = 1'b1;

    morse_stream_decoder i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Letter at a tree node; zero where the node holds none.
    function automatic logic [7:0] tree_letter(input int node);
        logic [7:0] code;
        code = TREE_LETTERS[8*(31 - node) +: 8];
        return (code == "*") ? 8'd0 : code;
    endfunction

    // Advances the decoder state by one character and tells whether it gives a result.
    function automatic bit decode_char(input logic [7:0] ch, input logic last,
                                       output t_decoded res);
        int node;
        bit is_symbol;
        is_symbol = (ch == msd_pkg::SYM_DOT) || (ch == msd_pkg::SYM_DASH);
        res = '0;
        if (is_symbol) begin
            if (group_len < msd_pkg::MAX_SYMBOLS) begin
                group_symbols = {group_symbols[2:0], ch == msd_pkg::SYM_DASH};
                group_len = group_len + 3'd1;
            end else begin
                group_len = msd_pkg::TOO_LONG;
            end
            if (!last) begin
                return 1'b0;
            end
        end
        if (group_len == 3'd0) begin
            if (!last) begin
                return 1'b0;
            end
            res.line_end = 1'b1;
            return 1'b1;
        end
        // A group of one to four symbols selects a node; a longer one has no letter.
        if (group_len <= msd_pkg::MAX_SYMBOLS) begin
            node = (1 << group_len) | (int'(group_symbols) & ((1 << group_len) - 1));
            res.letter = tree_letter(node);
        end
        res.has_letter   = 1'b1;
        res.unknown_code = (res.letter == 8'd0);
        res.line_end     = last;
        group_len     = 3'd0;
        group_symbols = 4'd0;
        return 1'b1;
    endfunction

    // Random character that ends a group: mostly a space.
    function automatic logic [7:0] random_separator();
        logic [7:0] ch;
        if ($urandom_range(0, 3) != 0) begin
            return CHAR_SPACE;
        end
        do begin
            ch = 8'($urandom_range(0, 255));
        end while (ch == msd_pkg::SYM_DOT || ch == msd_pkg::SYM_DASH);
        return ch;
    endfunction

    // Sends one character request, after a random gap when the sender idles, and records any result.
    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        t_decoded res;
        gap = send_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do @(posedge i_clk); while (!(s_tvalid && s_tready));
        items_sent++;
        if (decode_char(ch, last, res)) begin
            expected_letters.push_back(res);
        end
    endtask

    // Sends a string; the last flag goes on its final character when asked.
    task automatic send_text(input string txt, input logic last);
        for (int i = 0; i < txt.len(); i++) begin
            send_char(txt[i], last && (i == txt.len() - 1));
        end
    endtask

    // Holds the sender off until every result has come, then lets the pipeline settle.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_letters.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // One group of random shape: one to four symbols, an overlong group or noise.
    task automatic send_random_group();
        int kind;
        int len;
        bit closes_line;
        bit last_on_symbol;
        kind           = $urandom_range(0, 99);
        closes_line    = ($urandom_range(0, 3) == 0);
        last_on_symbol = 1'($urandom_range(0, 1));
        if (kind < 10) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
                send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end
        end else begin
            len = (kind < 15) ? $urandom_range(5, 7) : $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
                send_char($urandom_range(0, 1) ? msd_pkg::SYM_DASH : msd_pkg::SYM_DOT,
                          closes_line && last_on_symbol && (i == len - 1));
            end
            if (!(closes_line && last_on_symbol)) begin
                send_char(random_separator(), closes_line);
            end
        end
    endtask

    task automatic test_single_symbols();
        send_text(". ", 1'b0);
        send_text("-", 1'b1);
    endtask

    task automatic test_four_symbols();
        send_text("--.-", 1'b0);
        send_char(8'h00, 1'b0);
    endtask

    task automatic test_unknown_group();
        send_text("..--", 1'b0);
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_overlong_group();
        send_text("----- ", 1'b0);
    endtask

    task automatic test_empty_line();
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b1);
    endtask

    task automatic test_drain_pause();
        send_text(".-.. ", 1'b0);
        wait_for_results();
        send_text("-.-", 1'b1);
        wait_for_results();
    endtask

    task automatic test_random_lines();
        int target;
        int next_change;
        target      = items_sent + RANDOM_ITEMS;
        next_change = items_sent;
        while (items_sent < target) begin
            // Each stretch picks anew which sides idle.
            if (items_sent >= next_change) begin
                send_idle   = 1'($urandom_range(0, 1));
                recv_idle   = 1'($urandom_range(0, 1));
                next_change = items_sent + MODE_STRETCH;
            end
            send_random_group();
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    // Result side: a random stall before each result is taken when the receiver idles.
    initial begin
        int gap;
        wait (rst_n);
        @(posedge i_clk);
        forever begin
            gap = recv_idle ? $urandom_range(0, IDLE_MAX) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_tvalid && m_tready));
        end
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_decoded want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_letters.size() == 0) begin
                $error("result with no expectation: letter %0d", m_tdata);
                error_count++;
            end else begin
                want = expected_letters.pop_front();
                if (m_tdata !== want.letter) begin
                    $error("letter: expected %0d, got %0d", want.letter, m_tdata);
                    error_count++;
                end
                if (m_tuser[0] !== want.has_letter) begin
                    $error("has_letter: expected %0d, got %0d", want.has_letter, m_tuser[0]);
                    error_count++;
                end
                if (m_tuser[1] !== want.unknown_code) begin
                    $error("unknown_code: expected %0d, got %0d",
                           want.unknown_code, m_tuser[1]);
                    error_count++;
                end
                if (m_tlast !== want.line_end) begin
                    $error("line_end: expected %0d, got %0d", want.line_end, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Ends the run when no request moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Reset once, then the tests in turn.
    initial begin
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_symbols();
        test_four_symbols();
        test_unknown_group();
        test_overlong_group();
        test_empty_line();
        test_drain_pause();
        test_random_lines();
        wait_for_results();
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
